[rtl/potq_pkg.sv]
`timescale 1ns / 1ps

package potq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int BURST_BITS_DEF  = 16;

    localparam int PRIO_W   = 8;
    localparam int ID_W     = 6;
    localparam int BURST_W  = 16;
    localparam int TIME_W   = 22;
    localparam int SUM_W    = 28;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED      = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_NONE       = 2'd3
    } t_status;

    typedef enum logic {
        FN_ADD   = 1'b0,
        FN_SCHED = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_RSP_ADD,
        S_RSP_FULL,
        S_RSP_NONE,
        S_DR_CALC,
        S_DR_EMIT
    } t_state;

    typedef struct packed {
        logic    load_item;
        logic    ins_start;
        logic    ins_shift;
        logic    ins_put;
        logic    drn_start;
        logic    drn_calc;
        logic    drn_emit;
        logic    resp;
        t_status resp_code;
        logic    id_inc;
        logic    clear;
    } t_dp_cmd;

    typedef struct packed {
        logic len_zero;
        logic full;
        logic scan_stop;
        logic drain_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/priority_ordered_task_queue.sv]
`timescale 1ns / 1ps
// channel  | handshake                 | payload
// -------- | ------------------------- | ----------------------------------------------
// in       | i_in_valid / o_in_stall   | i_func, i_task_priority, i_task_burst
// out      | o_out_valid / i_out_stall | o_status, o_task_id, o_run_priority, o_run_burst,
//          |                           | o_start_time, o_finish_time, o_total_wait,
//          |                           | o_total_turnaround, o_task_count, o_last
//
// one word in flight: an add scans from the tail, moving each lower-priority entry
// up one slot, one per cycle through the single memory write port, then responds
// a drain takes a calc step and an emit step per queued task (saturating adds)
// a full add or an empty drain goes straight to its response step
// a stalled output word holds the sequencer in its response or emit step
// reset clears length, id counter and handshake state; queue memory is not swept

module priority_ordered_task_queue #(
    parameter int QUEUE_DEPTH = potq_pkg::QUEUE_DEPTH_DEF,
    parameter int BURST_BITS  = potq_pkg::BURST_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_func,
    input  logic [potq_pkg::PRIO_W-1:0]     i_task_priority,
    input  logic [potq_pkg::BURST_W-1:0]    i_task_burst,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [potq_pkg::STATUS_W-1:0]   o_status,
    output logic [potq_pkg::ID_W-1:0]       o_task_id,
    output logic [potq_pkg::PRIO_W-1:0]     o_run_priority,
    output logic [potq_pkg::BURST_W-1:0]    o_run_burst,
    output logic [potq_pkg::TIME_W-1:0]     o_start_time,
    output logic [potq_pkg::TIME_W-1:0]     o_finish_time,
    output logic [potq_pkg::SUM_W-1:0]      o_total_wait,
    output logic [potq_pkg::SUM_W-1:0]      o_total_turnaround,
    output logic [potq_pkg::COUNT_W-1:0]    o_task_count,
    output logic                            o_last
);

    potq_pkg::t_dp_cmd  cmd;
    potq_pkg::t_dp_stat stat;

    potq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    potq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BURST_BITS  (BURST_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_task_priority    (i_task_priority),
        .i_task_burst       (i_task_burst),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_task_id          (o_task_id),
        .o_run_priority     (o_run_priority),
        .o_run_burst        (o_run_burst),
        .o_start_time       (o_start_time),
        .o_finish_time      (o_finish_time),
        .o_total_wait       (o_total_wait),
        .o_total_turnaround (o_total_turnaround),
        .o_task_count       (o_task_count),
        .o_last             (o_last)
    );

endmodule

[rtl/potq_ctrl.sv]
`timescale 1ns / 1ps

module potq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_func,
    input  potq_pkg::t_dp_stat i_stat,
    output logic               o_in_stall,
    output potq_pkg::t_dp_cmd  o_cmd
);

    potq_pkg::t_state r_state;
    potq_pkg::t_state n_state;
    logic             accept;

    assign accept = i_in_valid && (r_state == potq_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= potq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            potq_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_func == potq_pkg::FN_ADD) begin
                        n_state = i_stat.full ? potq_pkg::S_RSP_FULL : potq_pkg::S_INS_SCAN;
                    end else begin
                        n_state = i_stat.len_zero ? potq_pkg::S_RSP_NONE : potq_pkg::S_DR_CALC;
                    end
                end
            end
            potq_pkg::S_INS_SCAN: begin
                if (i_stat.scan_stop) begin
                    n_state = potq_pkg::S_RSP_ADD;
                end
            end
            potq_pkg::S_RSP_ADD, potq_pkg::S_RSP_FULL, potq_pkg::S_RSP_NONE: begin
                if (i_stat.out_free) begin
                    n_state = potq_pkg::S_IDLE;
                end
            end
            potq_pkg::S_DR_CALC: begin
                n_state = potq_pkg::S_DR_EMIT;
            end
            potq_pkg::S_DR_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.drain_last ? potq_pkg::S_IDLE : potq_pkg::S_DR_CALC;
                end
            end
            default: begin
                n_state = potq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.resp_code = potq_pkg::ST_ADDED;
        o_in_stall      = (r_state != potq_pkg::S_IDLE);
        case (r_state)
            potq_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    if (i_func == potq_pkg::FN_ADD) begin
                        o_cmd.ins_start = !i_stat.full;
                    end else begin
                        o_cmd.drn_start = !i_stat.len_zero;
                    end
                end
            end
            potq_pkg::S_INS_SCAN: begin
                o_cmd.ins_put   = i_stat.scan_stop;
                o_cmd.ins_shift = !i_stat.scan_stop;
            end
            potq_pkg::S_RSP_ADD: begin
                o_cmd.resp      = i_stat.out_free;
                o_cmd.id_inc    = i_stat.out_free;
                o_cmd.resp_code = potq_pkg::ST_ADDED;
            end
            potq_pkg::S_RSP_FULL: begin
                o_cmd.resp      = i_stat.out_free;
                o_cmd.resp_code = potq_pkg::ST_FULL;
            end
            potq_pkg::S_RSP_NONE: begin
                o_cmd.resp      = i_stat.out_free;
                o_cmd.clear     = i_stat.out_free;
                o_cmd.resp_code = potq_pkg::ST_NONE;
            end
            potq_pkg::S_DR_CALC: begin
                o_cmd.drn_calc = 1'b1;
            end
            potq_pkg::S_DR_EMIT: begin
                o_cmd.drn_emit = i_stat.out_free;
                o_cmd.clear    = i_stat.out_free && i_stat.drain_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[rtl/potq_dp.sv]
`timescale 1ns / 1ps

module potq_dp #(
    parameter int QUEUE_DEPTH = potq_pkg::QUEUE_DEPTH_DEF,
    parameter int BURST_BITS  = potq_pkg::BURST_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  potq_pkg::t_dp_cmd               i_cmd,
    output potq_pkg::t_dp_stat              o_stat,
    input  logic [potq_pkg::PRIO_W-1:0]     i_task_priority,
    input  logic [potq_pkg::BURST_W-1:0]    i_task_burst,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [potq_pkg::STATUS_W-1:0]   o_status,
    output logic [potq_pkg::ID_W-1:0]       o_task_id,
    output logic [potq_pkg::PRIO_W-1:0]     o_run_priority,
    output logic [potq_pkg::BURST_W-1:0]    o_run_burst,
    output logic [potq_pkg::TIME_W-1:0]     o_start_time,
    output logic [potq_pkg::TIME_W-1:0]     o_finish_time,
    output logic [potq_pkg::SUM_W-1:0]      o_total_wait,
    output logic [potq_pkg::SUM_W-1:0]      o_total_turnaround,
    output logic [potq_pkg::COUNT_W-1:0]    o_task_count,
    output logic                            o_last
);

    localparam int SB  = (BURST_BITS < potq_pkg::BURST_W) ? BURST_BITS : potq_pkg::BURST_W;
    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int TW1 = potq_pkg::TIME_W + 1;
    localparam int SW1 = potq_pkg::SUM_W + 1;

    typedef struct packed {
        logic [potq_pkg::PRIO_W-1:0] prio;
        logic [potq_pkg::ID_W-1:0]   id;
        logic [SB-1:0]               burst;
    } t_entry;

    t_entry                        r_mem [QUEUE_DEPTH];
    t_entry                        r_rdata;
    t_entry                        r_ent;
    logic [LW-1:0]                 r_len;
    logic [LW-1:0]                 r_idx;
    logic [LW-1:0]                 n_idx;
    logic [LW-1:0]                 r_count;
    logic [potq_pkg::ID_W-1:0]     r_next_id;
    logic                          r_drain;
    logic [potq_pkg::PRIO_W-1:0]   r_prio;
    logic [SB-1:0]                 r_burst;
    logic [potq_pkg::TIME_W-1:0]   r_clock;
    logic [potq_pkg::TIME_W-1:0]   r_start;
    logic [potq_pkg::TIME_W-1:0]   r_finish;
    logic [potq_pkg::SUM_W-1:0]    r_wsum;
    logic [potq_pkg::SUM_W-1:0]    r_tsum;
    logic                          r_out_valid;

    logic                          drain_rd;
    logic [LW-1:0]                 rd_idx;
    logic [AW-1:0]                 rd_addr;
    logic                          we;
    logic [AW-1:0]                 wa;
    t_entry                        wd;
    logic [TW1-1:0]                fin_sum;
    logic [potq_pkg::TIME_W-1:0]   fin_sat;
    logic [SW1-1:0]                wsum_sum;
    logic [potq_pkg::SUM_W-1:0]    wsum_sat;
    logic [SW1-1:0]                tsum_sum;
    logic [potq_pkg::SUM_W-1:0]    tsum_sat;

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.ins_start) begin
            n_idx = r_len;
        end else if (i_cmd.drn_start) begin
            n_idx = '0;
        end else if (i_cmd.ins_shift) begin
            n_idx = r_idx - LW'(1);
        end else if (i_cmd.drn_emit) begin
            n_idx = r_idx + LW'(1);
        end
    end

    // insert scans from the tail and needs the entry below the index
    assign drain_rd = i_cmd.drn_start || (r_drain && !i_cmd.ins_start);

    always_comb begin
        if (drain_rd) begin
            rd_idx = n_idx;
        end else if (n_idx == '0) begin
            rd_idx = '0;
        end else begin
            rd_idx = n_idx - LW'(1);
        end
        rd_addr = (rd_idx < LW'(QUEUE_DEPTH)) ? rd_idx[AW-1:0] : '0;
    end

    assign we = i_cmd.ins_put || i_cmd.ins_shift;
    assign wa = r_idx[AW-1:0];

    always_comb begin
        if (i_cmd.ins_put) begin
            wd.prio  = r_prio;
            wd.id    = r_next_id;
            wd.burst = r_burst;
        end else begin
            wd = r_rdata;
        end
    end

    assign fin_sum  = {1'b0, r_clock} + TW1'(r_rdata.burst);
    assign fin_sat  = fin_sum[potq_pkg::TIME_W] ? '1 : fin_sum[potq_pkg::TIME_W-1:0];
    assign wsum_sum = {1'b0, r_wsum} + SW1'(r_clock);
    assign wsum_sat = wsum_sum[potq_pkg::SUM_W] ? '1 : wsum_sum[potq_pkg::SUM_W-1:0];
    assign tsum_sum = {1'b0, r_tsum} + SW1'(r_finish);
    assign tsum_sat = tsum_sum[potq_pkg::SUM_W] ? '1 : tsum_sum[potq_pkg::SUM_W-1:0];

    // equal priority stops the scan so arrival order holds
    assign o_stat.len_zero   = (r_len == '0);
    assign o_stat.full       = (r_len == LW'(QUEUE_DEPTH));
    assign o_stat.scan_stop  = (r_idx == '0) || (r_rdata.prio >= r_prio);
    assign o_stat.drain_last = ((r_idx + LW'(1)) == r_count);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_idx       <= '0;
            r_next_id   <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.ins_start) begin
                r_drain <= 1'b0;
            end else if (i_cmd.drn_start) begin
                r_drain <= 1'b1;
            end
            if (i_cmd.ins_put) begin
                r_len <= r_len + LW'(1);
            end
            if (i_cmd.id_inc) begin
                r_next_id <= r_next_id + potq_pkg::ID_W'(1);
            end
            if (i_cmd.resp || i_cmd.drn_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_len     <= '0;
                r_next_id <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_prio  <= i_task_priority;
            r_burst <= i_task_burst[SB-1:0];
        end
        if (i_cmd.drn_start) begin
            r_clock <= '0;
            r_wsum  <= '0;
            r_tsum  <= '0;
            r_count <= r_len;
        end
        if (i_cmd.drn_calc) begin
            r_ent    <= r_rdata;
            r_start  <= r_clock;
            r_finish <= fin_sat;
            r_wsum   <= wsum_sat;
        end
        if (i_cmd.drn_emit) begin
            r_tsum  <= tsum_sat;
            r_clock <= r_finish;
        end
        if (i_cmd.resp) begin
            o_status           <= i_cmd.resp_code;
            o_task_id          <= (i_cmd.resp_code == potq_pkg::ST_NONE) ? '0 : r_next_id;
            o_run_priority     <= '0;
            o_run_burst        <= '0;
            o_start_time       <= '0;
            o_finish_time      <= '0;
            o_total_wait       <= '0;
            o_total_turnaround <= '0;
            o_task_count       <= '0;
            o_last             <= 1'b1;
        end else if (i_cmd.drn_emit) begin
            o_status           <= potq_pkg::ST_DISPATCHED;
            o_task_id          <= r_ent.id;
            o_run_priority     <= r_ent.prio;
            o_run_burst        <= potq_pkg::BURST_W'(r_ent.burst);
            o_start_time       <= r_start;
            o_finish_time      <= r_finish;
            o_total_wait       <= r_wsum;
            o_total_turnaround <= tsum_sat;
            o_task_count       <= potq_pkg::COUNT_W'(r_count);
            o_last             <= o_stat.drain_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/potq_checker.sv]
`timescale 1ns / 1ps

module potq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_func,
    input logic [potq_pkg::PRIO_W-1:0]     i_task_priority,
    input logic [potq_pkg::BURST_W-1:0]    i_task_burst,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [potq_pkg::STATUS_W-1:0]   o_status,
    input logic [potq_pkg::ID_W-1:0]       o_task_id,
    input logic [potq_pkg::PRIO_W-1:0]     o_run_priority,
    input logic [potq_pkg::BURST_W-1:0]    o_run_burst,
    input logic [potq_pkg::TIME_W-1:0]     o_start_time,
    input logic [potq_pkg::TIME_W-1:0]     o_finish_time,
    input logic [potq_pkg::SUM_W-1:0]      o_total_wait,
    input logic [potq_pkg::SUM_W-1:0]      o_total_turnaround,
    input logic [potq_pkg::COUNT_W-1:0]    o_task_count,
    input logic                            o_last
);

    // a stalled output word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_task_id) && $stable(o_status) && $stable(o_last))
        else $error("output word changed under stall");

    // one word at a time: the next cycle after an accept is always stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // add, drop and empty results are single words
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != potq_pkg::ST_DISPATCHED |->
            o_last && o_task_count == '0 && o_total_wait == '0)
        else $error("non-dispatch word malformed");

    // a dispatched task never ends before it starts and comes from a nonempty drain
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == potq_pkg::ST_DISPATCHED |->
            o_finish_time >= o_start_time && o_task_count != '0
            && o_total_turnaround >= o_total_wait)
        else $error("dispatch timing inconsistent");

endmodule

bind priority_ordered_task_queue potq_checker u_potq_checker (.*);
